// ===== rtl/rtte_pkg.sv =====
// Package for the RTT estimator: command codes, stream widths and limits.
// No dependencies; imported by rtt_estimator_ewma.
`default_nettype none

package rtte_pkg;

	localparam int RTT_WIDTH_DEF = 16;

	localparam int CMD_W        = 2;
	localparam int DELAY_W      = 17;
	localparam int ACK_W        = 16;
	localparam int FIELD_W      = 16;
	localparam int S_DATA_W     = 40;
	localparam int M_DATA_W     = 80;

	localparam logic [FIELD_W-1:0] MAX_SEND_DELAY = 16'd60000;

	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_EXPIRE  = 2'd1,
		CMD_MIGRATE = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rtt_estimator_ewma.sv =====
// RTT estimator top level: input request register, one-pass update, result stage.
// Depends on rtte_pkg.
//
// Usage:
//   Slave stream s_*: one request per handshake. tuser carries the command
//   (sample, expire, migrate); tdata carries the send delta and the peer ack delay.
//   Master stream m_*: one result per request, the estimator state after it,
//   plus a rejected flag in tuser for a sample with a delta outside 1..60000.
//   The input register loads at the request handshake, and the state update loads
//   the result stage once that stage is empty or its result is being taken.
//   Throughput: one request per cycle while m_tready is high; the state update is
//   the loop that sets this figure.
//   Reset clears all estimator state to zero and empties both stages.
//   When the receiver stalls, the result holds, the input register holds one
//   more request, and s_tready drops only once both are full.
`default_nettype none

module rtt_estimator_ewma import rtte_pkg::*; #(
	parameter int RTT_WIDTH = RTT_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [16:0] send_delay_ms, [32:17] peer_ack_delay_ms, [39:33] zero
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// [1:0] command
	input  wire logic [CMD_W-1:0]    s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [15:0] latest_rtt_ms, [31:16] minimum_rtt_ms, [47:32] smoothed_rtt_ms,
	// [63:48] prior_smoothed_ms, [79:64] rtt_deviation_ms
	output logic [M_DATA_W-1:0]      m_tdata,
	// [0] sample_rejected
	output logic                     m_tuser
);

	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [DELAY_W-1:0] delay_s1;
	logic [ACK_W-1:0]   ack_s1;

	logic                 out_valid_q;
	logic                 rejected_q;
	logic [RTT_WIDTH-1:0] latest_q, minimum_q, smoothed_q, prior_q, deviation_q;

	logic                 advance;
	logic                 delta_bad;
	logic [RTT_WIDTH-1:0] x, ack, r, gap_sr, gap_sl;
	logic [RTT_WIDTH+2:0] sm_sum;
	logic [RTT_WIDTH+1:0] dev_sum;
	logic                 nxt_rejected;
	logic [RTT_WIDTH-1:0] nxt_latest, nxt_minimum, nxt_smoothed, nxt_prior, nxt_deviation;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1   <= s_tuser;
			delay_s1 <= s_tdata[DELAY_W-1:0];
			ack_s1   <= s_tdata[DELAY_W+ACK_W-1:DELAY_W];
		end
	end

	always_comb begin
		delta_bad = delay_s1[DELAY_W-1] || (delay_s1[FIELD_W-1:0] == '0)
			|| (delay_s1[FIELD_W-1:0] > MAX_SEND_DELAY);
		x   = RTT_WIDTH'(delay_s1[FIELD_W-1:0]);
		ack = RTT_WIDTH'(ack_s1);
		r   = (x > ack) ? (x - ack) : x;
		gap_sr = (smoothed_q > r) ? (smoothed_q - r) : (r - smoothed_q);
		gap_sl = (smoothed_q > latest_q) ? (smoothed_q - latest_q) : (latest_q - smoothed_q);
		sm_sum  = {smoothed_q, 3'b000} - {3'b000, smoothed_q} + {3'b000, r};
		dev_sum = {1'b0, deviation_q, 1'b0} + {2'b00, deviation_q} + {2'b00, gap_sr};

		nxt_rejected  = 1'b0;
		nxt_latest    = latest_q;
		nxt_minimum   = minimum_q;
		nxt_smoothed  = smoothed_q;
		nxt_prior     = prior_q;
		nxt_deviation = deviation_q;

		unique case (cmd_t'(cmd_s1))
			CMD_SAMPLE: begin
				if (delta_bad) begin
					nxt_rejected = 1'b1;
				end else begin
					if (minimum_q == '0 || minimum_q > x) begin
						nxt_minimum = x;
					end
					nxt_prior  = smoothed_q;
					nxt_latest = r;
					if (smoothed_q == '0) begin
						nxt_smoothed  = r;
						nxt_deviation = r >> 1;
					end else begin
						nxt_smoothed  = sm_sum[RTT_WIDTH+2:3];
						nxt_deviation = dev_sum[RTT_WIDTH+1:2];
					end
				end
			end
			CMD_EXPIRE: begin
				if (gap_sl > deviation_q) begin
					nxt_deviation = gap_sl;
				end
				if (latest_q > smoothed_q) begin
					nxt_smoothed = latest_q;
				end
			end
			CMD_MIGRATE: begin
				nxt_latest    = '0;
				nxt_minimum   = '0;
				nxt_smoothed  = '0;
				nxt_deviation = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rejected_q  <= 1'b0;
			latest_q    <= '0;
			minimum_q   <= '0;
			smoothed_q  <= '0;
			prior_q     <= '0;
			deviation_q <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				rejected_q  <= nxt_rejected;
				latest_q    <= nxt_latest;
				minimum_q   <= nxt_minimum;
				smoothed_q  <= nxt_smoothed;
				prior_q     <= nxt_prior;
				deviation_q <= nxt_deviation;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = rejected_q;
	assign m_tdata  = {deviation_q[FIELD_W-1:0], prior_q[FIELD_W-1:0],
		smoothed_q[FIELD_W-1:0], minimum_q[FIELD_W-1:0], latest_q[FIELD_W-1:0]};

endmodule

`default_nettype wire
